// ===== rtl/core/gh_pkg.sv =====
// Shared types, constants and the base-32 character table of the geohash encoder.
package gh_pkg;

  localparam int unsigned MAX_CHARS = 12;

  // Valid coordinate limits, in units of 1e-7 degree.
  localparam logic signed [31:0] LAT_HALF = 32'sd900000000;
  localparam logic signed [31:0] LON_HALF = 32'sd1800000000;

  // Full interval widths. The 2^30 fraction scale cancels out of the
  // bisection, so the residues are kept without it.
  localparam logic [30:0] LAT_SPAN = 31'd1800000000;
  localparam logic [31:0] LON_SPAN = 32'd3600000000;

  localparam logic [255:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

  typedef struct packed {
    logic load;
    logic step;
    logic lon_turn;
  } gh_ctl_t;

  typedef struct packed {
    logic [4:0] code;
    logic       last;
    logic       status;
  } gh_word_t;

  function automatic logic [7:0] gh_char_of(input logic [4:0] code);
    logic [4:0] idx;
    idx = ~code;
    return ALPHABET[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== rtl/core/gh_bisect.sv =====
// Bisection unit: while step is set, one compare-subtract per cycle on the lon or lat residue.
module gh_bisect (
  input  logic            clk,
  input  gh_pkg::gh_ctl_t ctl,
  input  logic [31:0]     lon_off,
  input  logic [30:0]     lat_off,
  output logic            bit_out
);
  import gh_pkg::*;

  logic [31:0] lon_r, lon_nxt;
  logic [30:0] lat_r, lat_nxt;
  logic [32:0] lon_dbl;
  logic [31:0] lat_dbl;
  logic        lon_gt, lat_gt;

  // Residue times two against the full span is the same test as the
  // coordinate against the midpoint of the current interval.
  assign lon_dbl = {lon_r, 1'b0};
  assign lat_dbl = {lat_r, 1'b0};
  assign lon_gt  = lon_dbl > {1'b0, LON_SPAN};
  assign lat_gt  = lat_dbl > {1'b0, LAT_SPAN};
  assign bit_out = ctl.lon_turn ? lon_gt : lat_gt;

  always_comb begin
    lon_nxt = lon_r;
    lat_nxt = lat_r;
    if (ctl.load) begin
      lon_nxt = lon_off;
      lat_nxt = lat_off;
    end else if (ctl.step) begin
      if (ctl.lon_turn) begin
        lon_nxt = lon_gt ? 32'(lon_dbl - {1'b0, LON_SPAN}) : lon_dbl[31:0];
      end else begin
        lat_nxt = lat_gt ? 31'(lat_dbl - {1'b0, LAT_SPAN}) : lat_dbl[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    lon_r <= lon_nxt;
    lat_r <= lat_nxt;
  end

endmodule

// ===== rtl/core/gh_digit.sv =====
// Character shift register: collects bisection bits, most significant first.
module gh_digit (
  input  logic            clk,
  input  gh_pkg::gh_ctl_t ctl,
  input  logic            bit_in,
  output logic [4:0]      code
);
  import gh_pkg::*;

  logic [4:0] code_r, code_nxt;

  always_comb begin
    code_nxt = code_r;
    if (ctl.load) begin
      code_nxt = '0;
    end else if (ctl.step) begin
      code_nxt = {code_r[3:0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign code = code_r;

endmodule

// ===== rtl/core/gh_outreg.sv =====
// Output register: holds one result word and maps the code to its ASCII character.
module gh_outreg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  gh_pkg::gh_word_t word,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_hash_char,
  output logic [4:0]       out_digit_code,
  output logic             out_last,
  output logic             out_status
);
  import gh_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic [4:0] code_r;
  logic       last_r, status_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // An error word carries a zero character and a zero code.
  always_ff @(posedge clk) begin
    if (load) begin
      char_r   <= word.status ? 8'h00 : gh_char_of(word.code);
      code_r   <= word.status ? 5'd0 : word.code;
      last_r   <= word.last;
      status_r <= word.status;
    end
  end

  assign out_valid      = valid_r;
  assign out_hash_char  = char_r;
  assign out_digit_code = code_r;
  assign out_last       = last_r;
  assign out_status     = status_r;

endmodule

// ===== rtl/core/geohash_encoder.sv =====
// Geohash encoder top level: input checks, bit sequencer and output handover.
//
//   channel | direction | handshake           | fields
//   in_     | input     | in_valid / in_stall | latitude, longitude, precision
//   out_    | output    | out_valid/out_stall | hash_char, digit_code, last, status
//
// Each character of a valid item takes five bisection steps through the single
// compare-subtract unit and then a handover of the word to the output register.
// in_stall is high from acceptance until the last character or the error word is
// handed over. Reset is synchronous and clears control state.
// While out_stall holds a full output register, the sequencer waits before each handover.
module geohash_encoder #(
  parameter int unsigned MAX_CHARS = gh_pkg::MAX_CHARS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic [3:0]         in_precision,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_hash_char,
  output logic [4:0]         out_digit_code,
  output logic               out_last,
  output logic               out_status
);
  import gh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] bitcnt_r, bitcnt_nxt;
  logic [3:0] chars_r, chars_nxt;
  logic [3:0] prec_r, prec_nxt;
  logic       turn_r, turn_nxt;

  logic        accept, in_ok, out_free, last_w, load_out;
  logic [32:0] lon_sum, lat_sum;
  logic        bit_w;
  logic [4:0]  code_w;
  gh_ctl_t     ctl;
  gh_word_t    word;

  assign in_ok = (in_latitude >= -LAT_HALF) && (in_latitude <= LAT_HALF) &&
                 (in_longitude >= -LON_HALF) && (in_longitude <= LON_HALF) &&
                 (in_precision != 4'd0) && (in_precision <= 4'(MAX_CHARS));

  assign lon_sum = 33'(in_longitude) + 33'(LON_HALF);
  assign lat_sum = 33'(in_latitude) + 33'(LAT_HALF);

  assign in_stall = state_r != ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_w   = 4'(chars_r + 4'd1) == prec_r;

  assign ctl.load     = accept && in_ok;
  assign ctl.step     = state_r == ST_STEP;
  assign ctl.lon_turn = turn_r;

  always_comb begin
    state_nxt  = state_r;
    bitcnt_nxt = bitcnt_r;
    chars_nxt  = chars_r;
    prec_nxt   = prec_r;
    turn_nxt   = turn_r;
    load_out   = 1'b0;
    word.code   = code_w;
    word.last   = last_w;
    word.status = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ok) begin
            state_nxt  = ST_STEP;
            bitcnt_nxt = '0;
            chars_nxt  = '0;
            prec_nxt   = in_precision;
            turn_nxt   = 1'b1;
          end else begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_STEP: begin
        turn_nxt   = !turn_r;
        bitcnt_nxt = 3'(bitcnt_r + 3'd1);
        if (bitcnt_r == 3'd4) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          chars_nxt  = 4'(chars_r + 4'd1);
          bitcnt_nxt = '0;
          state_nxt  = last_w ? ST_IDLE : ST_STEP;
        end
      end
      ST_ERR: begin
        word.last   = 1'b1;
        word.status = 1'b1;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bitcnt_r <= '0;
      chars_r  <= '0;
      prec_r   <= '0;
      turn_r   <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      bitcnt_r <= bitcnt_nxt;
      chars_r  <= chars_nxt;
      prec_r   <= prec_nxt;
      turn_r   <= turn_nxt;
    end
  end

  gh_bisect u_bisect (
    .clk     (clk),
    .ctl     (ctl),
    .lon_off (lon_sum[31:0]),
    .lat_off (lat_sum[30:0]),
    .bit_out (bit_w)
  );

  gh_digit u_digit (
    .clk    (clk),
    .ctl    (ctl),
    .bit_in (bit_w),
    .code   (code_w)
  );

  gh_outreg u_outreg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load_out),
    .word           (word),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_hash_char  (out_hash_char),
    .out_digit_code (out_digit_code),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  // An error word is always the only word of its item and carries no character.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_hash_char == 8'h00 && out_digit_code == 5'd0)
    else $error("error word malformed");

  // A good word always carries a printable character.
  a_ok_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_hash_char != 8'h00)
    else $error("good word without character");

  // The sequencer never runs past the requested number of characters.
  a_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP || state_r == ST_EMIT) |-> chars_r < prec_r)
    else $error("character count overran precision");

endmodule
